/* rtl/cru_pkg.sv */
`timescale 1ns / 1ps

package cru_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int TAP_W       = 16;
   localparam int PARTIAL_W   = 48;
   localparam int RESULT_W    = 48;
   localparam int COLUMN_W    = 12;
   localparam int WIDTH_W     = 13;
   localparam int PROD_W      = SAMPLE_W + TAP_W;
   localparam int KERNEL_TAPS = 5;
   localparam int LEFT_PAD    = 1;
   localparam int MAX_WIDTH   = 4096;
   localparam int SUM_W       = PROD_W + $clog2(KERNEL_TAPS);
   localparam int ACC_W       = RESULT_W + 1;

   // Shifts between a sample's arrival and the column that it closes.
   localparam int LAG         = KERNEL_TAPS - 1 - LEFT_PAD;
   localparam int FLUSH_W     = $clog2(LAG + 1);
   localparam int TAP_IDX_W   = $clog2(KERNEL_TAPS);

   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAP0      = 3'd0,
      CSR_TAP1      = 3'd1,
      CSR_TAP2      = 3'd2,
      CSR_TAP3      = 3'd3,
      CSR_TAP4      = 3'd4,
      CSR_IN_WIDTH  = 3'd5,
      CSR_OUT_WIDTH = 3'd6,
      CSR_RELU_ON   = 3'd7
   } csr_reg_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

endpackage

/* rtl/conv_row_5tap_accumulate_unit.sv */
`timescale 1ns / 1ps

// Five-tap row convolution with accumulation, stride one, one pad sample on the left.
// The req channel takes one sample of a row per transfer together with the running
// partial sum for the output column of the same index. The rsp channel returns one
// result per output column, with its column index, and tlast on the last column.
// Column x leaves when sample x+3 has been taken; the last sample of a row is followed
// by internal flush shifts that close the remaining columns, during which req_tready
// is low. Otherwise one sample is taken every cycle while no result is stalled.
// Between a req transfer and the matching rsp_tvalid lie the registered stages for
// the five products in the cell chain, the product sum, and the final add,
// saturation and rectification.
// The csr port writes taps, row widths and the rectify flag; write it only while idle.
// Reset (synchronous) clears the sample window, the column count and all valid
// flags, and loads the register reset values. When rsp_tready is low with a result
// waiting, the whole pipeline holds and req_tready drops in the same cycle.

module conv_row_5tap_accumulate_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [15:0] sample, [63:16] partial
   input  logic [cru_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [47:0] result, [59:48] column, [63:60] zero
   output logic [cru_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [cru_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cru_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import cru_pkg::*;

   // Configuration registers.
   logic signed [TAP_W-1:0] tap_ff [KERNEL_TAPS];
   logic [WIDTH_W-1:0]      in_width_ff;
   logic [WIDTH_W-1:0]      out_width_ff;
   logic                    relu_on_ff;

   // Row control.
   logic [WIDTH_W-1:0] count_ff;
   logic [WIDTH_W-1:0] count_in;
   logic [FLUSH_W-1:0] flush_left_ff;
   logic [FLUSH_W-1:0] flush_left_in;
   logic [WIDTH_W-1:0] flush_pos_ff;
   logic [WIDTH_W-1:0] flush_pos_in;

   logic               advance;
   logic               flushing;
   logic               take;
   logic               last;
   logic [WIDTH_W-1:0] eff_in;
   logic [WIDTH_W-1:0] eff_out;
   logic [WIDTH_W-1:0] pos;
   logic [WIDTH_W-1:0] col;
   logic               emit;
   cell_ctrl_type      cell_ctrl;

   logic signed [SAMPLE_W-1:0]  sample_chain  [KERNEL_TAPS+1];
   logic signed [PARTIAL_W-1:0] partial_chain [KERNEL_TAPS+1];
   logic signed [PROD_W-1:0]    product       [KERNEL_TAPS];

   // Pipeline stages.
   logic                        s1_valid_ff;
   logic [COLUMN_W-1:0]         s1_column_ff;
   logic                        s1_last_ff;
   logic signed [PARTIAL_W-1:0] s1_partial_ff;

   logic                        s2_valid_ff;
   logic [COLUMN_W-1:0]         s2_column_ff;
   logic                        s2_last_ff;
   logic signed [PARTIAL_W-1:0] s2_partial_ff;
   logic signed [SUM_W-1:0]     s2_sum_ff;
   logic signed [SUM_W-1:0]     s2_sum_in;

   logic                        rsp_valid_ff;
   logic [COLUMN_W-1:0]         rsp_column_ff;
   logic                        rsp_last_ff;
   logic signed [RESULT_W-1:0]  rsp_result_ff;
   logic signed [RESULT_W-1:0]  rsp_result_in;
   logic signed [ACC_W-1:0]     acc;

   // ---------------------------------------------------------------- config
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KERNEL_TAPS; k++) begin
            tap_ff[k] <= '0;
         end
         in_width_ff  <= WIDTH_W'(4096);
         out_width_ff <= WIDTH_W'(4094);
         relu_on_ff   <= 1'b0;
      end else if (csr_we) begin
         case (csr_reg_type'(csr_index))
            CSR_TAP0, CSR_TAP1, CSR_TAP2, CSR_TAP3, CSR_TAP4: begin
               tap_ff[csr_index[TAP_IDX_W-1:0]] <= csr_wdata[TAP_W-1:0];
            end
            CSR_IN_WIDTH: begin
               in_width_ff <= csr_wdata[WIDTH_W-1:0];
            end
            CSR_OUT_WIDTH: begin
               out_width_ff <= csr_wdata[WIDTH_W-1:0];
            end
            CSR_RELU_ON: begin
               relu_on_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // ---------------------------------------------------------------- control
   always_comb begin
      if (in_width_ff == '0) begin
         eff_in = WIDTH_W'(1);
      end else if (int'(in_width_ff) > MAX_WIDTH) begin
         eff_in = WIDTH_W'(MAX_WIDTH);
      end else begin
         eff_in = in_width_ff;
      end
      eff_out = (out_width_ff < eff_in) ? out_width_ff : eff_in;
   end

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign flushing   = (flush_left_ff != '0);
   assign req_tready = advance && !flushing;
   assign take       = req_tvalid && req_tready;
   assign last       = (count_ff >= eff_in - WIDTH_W'(1));

   assign pos  = flushing ? flush_pos_ff : count_ff;
   assign col  = pos - WIDTH_W'(LAG);
   assign emit = (pos >= WIDTH_W'(LAG)) && (col < eff_out);

   // The final flush shift also returns the window to zero for the next row.
   assign cell_ctrl.shift = take || (advance && flushing);
   assign cell_ctrl.clear = flushing && (flush_left_ff == FLUSH_W'(1));

   always_comb begin
      count_in      = count_ff;
      flush_left_in = flush_left_ff;
      flush_pos_in  = flush_pos_ff;
      if (advance && flushing) begin
         flush_left_in = flush_left_ff - FLUSH_W'(1);
         flush_pos_in  = flush_pos_ff + WIDTH_W'(1);
      end else if (take) begin
         if (last) begin
            count_in      = '0;
            flush_left_in = FLUSH_W'(LAG);
            flush_pos_in  = count_ff + WIDTH_W'(1);
         end else begin
            count_in = count_ff + WIDTH_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         flush_left_ff <= '0;
         flush_pos_ff  <= '0;
      end else begin
         count_ff      <= count_in;
         flush_left_ff <= flush_left_in;
         flush_pos_ff  <= flush_pos_in;
      end
   end

   // ---------------------------------------------------------------- cell chain
   // Samples enter at the top cell and move down one cell per shift; flush
   // shifts feed zeros, which stand for the samples beyond the row end.
   assign sample_chain[KERNEL_TAPS]  = flushing ? '0 : req_tdata[SAMPLE_W-1:0];
   assign partial_chain[KERNEL_TAPS] = flushing ? '0 : req_tdata[SAMPLE_W +: PARTIAL_W];

   for (genvar g = 0; g < KERNEL_TAPS; g++) begin : g_cell
      cru_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .tap         (tap_ff[g]),
         .sample_in   (sample_chain[g+1]),
         .partial_in  (partial_chain[g+1]),
         .sample_out  (sample_chain[g]),
         .partial_out (partial_chain[g]),
         .product     (product[g])
      );
   end

   // ---------------------------------------------------------------- sum stages
   always_comb begin
      s2_sum_in = '0;
      for (int k = 0; k < KERNEL_TAPS; k++) begin
         s2_sum_in = s2_sum_in + SUM_W'(product[k]);
      end
   end

   always_comb begin
      acc = ACC_W'(s2_partial_ff) + ACC_W'(s2_sum_ff);
      if (acc[ACC_W-1] != acc[ACC_W-2]) begin
         rsp_result_in = acc[ACC_W-1] ? {1'b1, {(RESULT_W-1){1'b0}}}
                                      : {1'b0, {(RESULT_W-1){1'b1}}};
      end else begin
         rsp_result_in = acc[RESULT_W-1:0];
      end
      if (relu_on_ff && rsp_result_in[RESULT_W-1]) begin
         rsp_result_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= cell_ctrl.shift && emit;
         s2_valid_ff  <= s1_valid_ff;
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   // The partial of the column sits in the same cell that holds
   // the column's own sample.
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_column_ff  <= col[COLUMN_W-1:0];
         s1_last_ff    <= (col == eff_out - WIDTH_W'(1));
         s1_partial_ff <= partial_chain[2];
         s2_column_ff  <= s1_column_ff;
         s2_last_ff    <= s1_last_ff;
         s2_partial_ff <= s1_partial_ff;
         s2_sum_ff     <= s2_sum_in;
         rsp_column_ff <= s2_column_ff;
         rsp_last_ff   <= s2_last_ff;
         rsp_result_ff <= rsp_result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RESULT_W - COLUMN_W)'(0), rsp_column_ff, rsp_result_ff};

endmodule

/* rtl/cru_cell.sv */
`timescale 1ns / 1ps

module cru_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cru_pkg::cell_ctrl_type               ctrl,
   input  logic signed [cru_pkg::TAP_W-1:0]     tap,
   input  logic signed [cru_pkg::SAMPLE_W-1:0]  sample_in,
   input  logic signed [cru_pkg::PARTIAL_W-1:0] partial_in,
   output logic signed [cru_pkg::SAMPLE_W-1:0]  sample_out,
   output logic signed [cru_pkg::PARTIAL_W-1:0] partial_out,
   output logic signed [cru_pkg::PROD_W-1:0]    product
);
   import cru_pkg::*;

   logic signed [SAMPLE_W-1:0]  sample_ff;
   logic signed [PARTIAL_W-1:0] partial_ff;
   logic signed [PROD_W-1:0]    product_ff;
   logic signed [PROD_W-1:0]    product_in;

   // The product is taken on the sample entering the cell, so it lines up
   // with the window position that this cell covers after the shift.
   assign product_in = sample_in * tap;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff  <= '0;
         partial_ff <= '0;
      end else if (ctrl.shift) begin
         if (ctrl.clear) begin
            sample_ff  <= '0;
            partial_ff <= '0;
         end else begin
            sample_ff  <= sample_in;
            partial_ff <= partial_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         product_ff <= product_in;
      end
   end

   assign sample_out  = sample_ff;
   assign partial_out = partial_ff;
   assign product     = product_ff;

endmodule

/* rtl/cru_checker.sv */
`timescale 1ns / 1ps

module cru_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [cru_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);
   import cru_pkg::*;

   // A stalled result holds its contents until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp payload changed while stalled");

   // A stalled result stalls the input side in the same cycle.
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("req_tready high while rsp is stalled");

   // After reset, no result appears until the cleared stage valid flags refill.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid ##1 !rsp_tvalid)
      else $error("rsp_tvalid too soon after reset");

   // The pad bits above the column field stay zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:RESULT_W+COLUMN_W] == '0)
      else $error("rsp_tdata pad bits not zero");

   // A sample may be taken in the cycle right after reset, but no result is
   // waiting beside it then.
   a_reset_req: assert property (@(posedge clock)
      reset |=> !(req_tvalid && req_tready && rsp_tvalid))
      else $error("unexpected activity after reset");

endmodule

bind conv_row_5tap_accumulate_unit cru_checker u_cru_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
